// ===== design/rse_pkg.sv =====
`default_nettype none
package rse_pkg;

    localparam int MSG_LEN    = 223;
    localparam int PARITY_LEN = 32;
    localparam int IDX_W      = $clog2(PARITY_LEN);

    // reduction term of x^8 + x^7 + x^2 + x + 1
    localparam logic [7:0] FIELD_LOW = 8'h87;

    typedef enum logic [1:0] {
        S_DATA,
        S_PAD,
        S_PARITY
    } t_state;

    // shift command from the controller to every remainder cell
    typedef struct packed {
        logic       en;
        logic [7:0] fb;
    } t_cell_ctl;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] acc;
        x   = {1'b0, a};
        y   = b;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (y[0]) begin
                acc = acc ^ x[7:0];
            end
            y = y >> 1;
            x = x << 1;
            if (x[8]) begin
                x = {1'b0, x[7:0] ^ FIELD_LOW};
            end
        end
        return acc;
    endfunction

    // generator coefficient k, k = 0 is the x^32 term; evaluated at elaboration
    function automatic logic [7:0] gen_coef(input int k);
        logic [7:0] p [PARITY_LEN+1];
        logic [7:0] root;
        root = 8'h01;
        for (int i = 0; i <= PARITY_LEN; i++) begin
            p[i] = 8'h00;
        end
        p[0] = 8'h01;
        for (int i = 1; i <= PARITY_LEN; i++) begin
            root = gf_mul(root, 8'h02);
            for (int j = PARITY_LEN; j > 0; j--) begin
                p[j] = p[j-1] ^ gf_mul(p[j], root);
            end
            p[0] = gf_mul(p[0], root);
        end
        return p[PARITY_LEN-k];
    endfunction

endpackage
`default_nettype wire

// ===== design/rse_if.sv =====
`default_nettype none
interface rse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_parity;
    logic       end_of_codeword;

    modport source (output valid, output out_byte, output is_parity,
                    output end_of_codeword, input ready);
    modport sink   (input valid, input out_byte, input is_parity,
                    input end_of_codeword, output ready);
endinterface
`default_nettype wire

// ===== design/rs_255_223_encoder.sv =====
// Data item: registered into the output register on acceptance, shown from the next cycle.
// Block end: internal zero padding up to MSG_LEN bytes when the block is short, then
// 32 parity items, one per cycle while the sink is ready. Throughput: one byte per cycle
// in a block while the output slot is free; the 32-cell remainder chain takes one shift
// per cycle. Synchronous active-low reset clears remainder and counters.
`default_nettype none
module rs_255_223_encoder #(
    parameter int MSG_LEN = rse_pkg::MSG_LEN
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rse_in_if.sink    i_in,
    rse_out_if.source o_out
);

    localparam int PL = rse_pkg::PARITY_LEN;

    rse_pkg::t_cell_ctl ctl;
    logic [7:0]         rem [PL+1];

    assign rem[PL] = 8'h00;

    rse_ctrl #(
        .MSG_LEN (MSG_LEN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_rem0  (rem[0]),
        .o_ctl   (ctl)
    );

    for (genvar j = 0; j < PL; j++) begin : g_cell
        rse_cell #(
            .COEF (rse_pkg::gen_coef(j + 1))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_up    (rem[j+1]),
            .o_val   (rem[j])
        );
    end

endmodule
`default_nettype wire

// ===== design/rse_cell.sv =====
`default_nettype none
module rse_cell #(
    parameter logic [7:0] COEF = 8'h01
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rse_pkg::t_cell_ctl i_ctl,
    input  wire logic [7:0]         i_up,
    output logic [7:0]              o_val
);

    logic [7:0] r_val;
    logic [7:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.en) begin
            n_val = i_up ^ rse_pkg::gf_mul(i_ctl.fb, COEF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 8'h00;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

// ===== design/rse_ctrl.sv =====
`default_nettype none
module rse_ctrl #(
    parameter int MSG_LEN = rse_pkg::MSG_LEN
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    rse_in_if.sink              i_in,
    rse_out_if.source           o_out,
    input  wire logic [7:0]     i_rem0,
    output rse_pkg::t_cell_ctl  o_ctl
);

    localparam int CW = $clog2(MSG_LEN + 1);
    localparam logic [CW-1:0] LEN_C = CW'(MSG_LEN);
    localparam logic [rse_pkg::IDX_W-1:0] IDX_LAST = rse_pkg::IDX_W'(rse_pkg::PARITY_LEN - 1);

    rse_pkg::t_state             r_state, n_state;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [rse_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_ov, n_ov;
    logic [7:0]                  r_byte, n_byte;
    logic                        r_par, n_par;
    logic                        r_eoc, n_eoc;

    logic          slot_free;
    logic          in_acc;
    logic [CW-1:0] cnt_inc;

    assign slot_free  = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == rse_pkg::S_DATA) && slot_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign cnt_inc    = r_cnt + CW'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ov    = r_ov;
        n_byte  = r_byte;
        n_par   = r_par;
        n_eoc   = r_eoc;
        o_ctl   = '0;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            rse_pkg::S_DATA: begin
                if (in_acc) begin
                    o_ctl.en = 1'b1;
                    o_ctl.fb = i_in.data_byte ^ i_rem0;
                    n_ov     = 1'b1;
                    n_byte   = i_in.data_byte;
                    n_par    = 1'b0;
                    n_eoc    = 1'b0;
                    if (cnt_inc >= LEN_C) begin
                        n_state = rse_pkg::S_PARITY;
                        n_idx   = '0;
                        n_cnt   = '0;
                    end else if (i_in.end_of_message) begin
                        // short block: clock zeros up to full length
                        n_state = rse_pkg::S_PAD;
                        n_cnt   = cnt_inc;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            rse_pkg::S_PAD: begin
                o_ctl.en = 1'b1;
                o_ctl.fb = i_rem0;
                n_cnt    = cnt_inc;
                if (cnt_inc >= LEN_C) begin
                    n_state = rse_pkg::S_PARITY;
                    n_idx   = '0;
                    n_cnt   = '0;
                end
            end
            rse_pkg::S_PARITY: begin
                if (slot_free) begin
                    // shift the remainder out, zero fills from the top
                    o_ctl.en = 1'b1;
                    o_ctl.fb = 8'h00;
                    n_ov     = 1'b1;
                    n_byte   = i_rem0;
                    n_par    = 1'b1;
                    n_eoc    = (r_idx == IDX_LAST);
                    n_idx    = r_idx + rse_pkg::IDX_W'(1);
                    if (r_idx == IDX_LAST) begin
                        n_state = rse_pkg::S_DATA;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = rse_pkg::S_DATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::S_DATA;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_par  <= n_par;
        r_eoc  <= n_eoc;
    end

    assign o_out.valid           = r_ov;
    assign o_out.out_byte        = r_byte;
    assign o_out.is_parity       = r_par;
    assign o_out.end_of_codeword = r_eoc;

    a_pad_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::S_PAD) |-> (r_cnt < LEN_C))
        else $error("pad count out of range");

    a_eoc_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_eoc) |-> r_par)
        else $error("end of codeword on a data item");

    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::S_PARITY && slot_free && r_idx == IDX_LAST)
        |=> (r_state == rse_pkg::S_DATA && r_cnt == '0 && r_eoc))
        else $error("block did not restart after last parity");

    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.end_of_message && cnt_inc < LEN_C)
        |=> (r_state == rse_pkg::S_DATA && r_cnt == $past(cnt_inc)))
        else $error("mid-block item left data state");

endmodule
`default_nettype wire
